FILE: design/assert_macros.svh
// assertion macros shared by the clock core
// no dependencies; clock and reset are passed in by the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TCC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcc assertion failed");
`define TCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcc assertion failed");
`else
`define TCC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define TCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/tcc_pkg.sv
// shared constants, codes and control structs of the clock core
// no dependencies
package tcc_pkg;

    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_MODE   = 3'd1;
    localparam logic [2:0] CMD_UP     = 3'd2;
    localparam logic [2:0] CMD_DOWN   = 3'd3;
    localparam logic [2:0] CMD_CHIME  = 3'd4;
    localparam logic [2:0] CMD_SERIAL = 3'd5;

    localparam logic [1:0] CFG_DRIFT_PERIOD = 2'd0;
    localparam logic [1:0] CFG_TICKS_PER_SEC = 2'd1;
    localparam logic [1:0] CFG_REPORT_DIV    = 2'd2;

    localparam logic [15:0] RST_DRIFT_PERIOD = 16'd2789;
    localparam logic [7:0]  RST_TICKS_PER_SEC = 8'd20;
    localparam logic [15:0] RST_REPORT_DIV    = 16'd10;

    localparam logic [4:0] RST_HOURS   = 5'd11;
    localparam logic [5:0] RST_MINUTES = 6'd59;
    localparam logic [5:0] RST_SECONDS = 6'd57;

    localparam logic [1:0] MODE_RUN     = 2'd0;
    localparam logic [1:0] MODE_SET_HRS = 2'd1;
    localparam logic [1:0] MODE_SET_MIN = 2'd2;

    localparam logic [7:0] RD_HOURS   = 8'd0;
    localparam logic [7:0] RD_MINUTES = 8'd1;
    localparam logic [7:0] RD_SECONDS = 8'd2;
    localparam logic [7:0] RD_PHASE   = 8'd3;
    localparam logic [7:0] RD_PHASE_B = 8'd4;
    localparam logic [7:0] RD_MODE    = 8'd5;
    localparam logic [7:0] RD_CHIME   = 8'd6;
    localparam logic [7:0] RD_DRIFT   = 8'd7;
    localparam logic [7:0] SET_HRS_BASE = 8'd8;
    localparam logic [7:0] SET_MIN_BASE = 8'd32;
    localparam logic [7:0] SET_SEC_BASE = 8'd92;
    localparam logic [7:0] SET_END      = 8'd152;

    localparam logic [7:0] REPLY_OK  = 8'h21;
    localparam logic [7:0] REPLY_BAD = 8'h3F;
    localparam logic [7:0] REPLY_SAT = 8'd255;

    localparam int DIV_W = 16;

    typedef struct packed {
        logic capture;
        logic exec;
        logic div_start;
        logic load_div;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_read_drift;
        logic div_done;
        logic out_free;
    } t_ctrl_stat;

endpackage

FILE: design/tcc_div.sv
// restoring divider, one quotient bit per cycle
// depends on tcc_pkg
module tcc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tcc_pkg::DIV_W-1:0]  i_dividend,
    input  logic [tcc_pkg::DIV_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [tcc_pkg::DIV_W-1:0]  o_quotient
);

    logic [tcc_pkg::DIV_W-1:0] r_rem, n_rem;
    logic [tcc_pkg::DIV_W-1:0] r_quo, n_quo;
    logic [tcc_pkg::DIV_W-1:0] r_dsr;
    logic [3:0]                r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [tcc_pkg::DIV_W:0]   w_shift;
    logic [tcc_pkg::DIV_W:0]   w_diff;
    logic                      w_ge;

    always_comb begin
        w_shift = {r_rem, r_quo[tcc_pkg::DIV_W-1]};
        w_ge    = w_shift >= {1'b0, r_dsr};
        w_diff  = w_shift - {1'b0, r_dsr};
        n_rem   = w_ge ? w_diff[tcc_pkg::DIV_W-1:0] : w_shift[tcc_pkg::DIV_W-1:0];
        n_quo   = {r_quo[tcc_pkg::DIV_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dsr  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: design/tcc_datapath.sv
// clock state, configuration, request and result registers
// depends on tcc_pkg and tcc_div
module tcc_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tcc_pkg::t_ctrl_cmd     i_ctrl,
    output tcc_pkg::t_ctrl_stat    o_stat,
    input  logic [2:0]             i_command,
    input  logic [7:0]             i_serial_byte,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [15:0]            i_cfg_data,
    input  logic                   i_stall,
    output logic                   o_valid,
    output logic                   o_reply_valid,
    output logic [7:0]             o_reply_byte,
    output logic [4:0]             o_hours_now,
    output logic [5:0]             o_minutes_now,
    output logic [5:0]             o_seconds_now,
    output logic [1:0]             o_mode_now,
    output logic                   o_phase_now,
    output logic                   o_chime_on,
    output logic                   o_drift_pulse,
    output logic                   o_chime_toggle
);

    logic [15:0] r_drift_period;
    logic [7:0]  r_tps;
    logic [15:0] r_report_div;

    logic [2:0]  r_cmd;
    logic [7:0]  r_byte;

    logic [7:0]  r_tick, n_tick;
    logic [15:0] r_drift, n_drift;
    logic [4:0]  r_hours, n_hours;
    logic [5:0]  r_minutes, n_minutes;
    logic [5:0]  r_seconds, n_seconds;
    logic [1:0]  r_mode, n_mode;
    logic        r_phase, n_phase;
    logic        r_chime, n_chime;

    logic        n_rvalid;
    logic [7:0]  n_rbyte;
    logic        n_dpulse;
    logic        n_ctoggle;

    logic        r_out_valid;
    logic [7:0]  r_reply_byte;
    logic        r_reply_valid;
    logic [4:0]  r_hours_o;
    logic [5:0]  r_minutes_o;
    logic [5:0]  r_seconds_o;
    logic [1:0]  r_mode_o;
    logic        r_phase_o;
    logic        r_chime_o;
    logic        r_dpulse_o;
    logic        r_ctoggle_o;

    logic        w_div_done;
    logic [15:0] w_quo;
    logic [7:0]  w_readout;

    tcc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctrl.div_start),
        .i_dividend (r_drift),
        .i_divisor  (r_report_div),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // zero divisor gives an all-ones quotient, which saturates as well
    assign w_readout = (w_quo > 16'd255) ? tcc_pkg::REPLY_SAT : w_quo[7:0];

    always_comb begin
        logic [7:0]  t_inc;
        logic [15:0] d_inc;
        logic [5:0]  s_inc;
        logic [6:0]  m_inc;
        logic [5:0]  h_inc;
        t_inc     = r_tick + 8'd1;
        d_inc     = r_drift + 16'd1;
        s_inc     = r_seconds;
        m_inc     = {1'b0, r_minutes};
        h_inc     = {1'b0, r_hours};
        n_tick    = r_tick;
        n_drift   = r_drift;
        n_hours   = r_hours;
        n_minutes = r_minutes;
        n_seconds = r_seconds;
        n_mode    = r_mode;
        n_phase   = r_phase;
        n_chime   = r_chime;
        n_rvalid  = 1'b0;
        n_rbyte   = '0;
        n_dpulse  = 1'b0;
        n_ctoggle = 1'b0;
        case (r_cmd)
            tcc_pkg::CMD_TICK: begin
                if (t_inc >= r_tps) begin
                    n_tick = '0;
                    s_inc  = r_seconds + 6'd1;
                    if (d_inc >= r_drift_period) begin
                        n_drift  = '0;
                        s_inc    = s_inc + 6'd1;
                        n_dpulse = 1'b1;
                    end else begin
                        n_drift = d_inc;
                    end
                    n_phase = ~r_phase;
                    if (s_inc >= 6'd60) begin
                        s_inc = s_inc - 6'd60;
                        m_inc = m_inc + 7'd1;
                    end
                    if (m_inc >= 7'd60) begin
                        m_inc = '0;
                        h_inc = h_inc + 6'd1;
                    end
                    if (h_inc >= 6'd24) begin
                        h_inc = '0;
                    end
                    n_seconds = s_inc;
                    n_minutes = m_inc[5:0];
                    n_hours   = h_inc[4:0];
                    n_ctoggle = r_chime && (r_mode == tcc_pkg::MODE_RUN) &&
                                (n_minutes == 6'd0) &&
                                (n_seconds == 6'd0 || n_seconds == 6'd1);
                end else begin
                    n_tick = t_inc;
                end
            end
            tcc_pkg::CMD_MODE: begin
                if (r_mode >= tcc_pkg::MODE_SET_MIN) begin
                    n_mode    = tcc_pkg::MODE_RUN;
                    n_seconds = '0;
                    n_tick    = '0;
                    n_drift   = '0;
                end else begin
                    n_mode = r_mode + 2'd1;
                end
            end
            tcc_pkg::CMD_UP: begin
                if (r_mode == tcc_pkg::MODE_SET_HRS) begin
                    n_hours = (r_hours >= 5'd23) ? 5'd0 : r_hours + 5'd1;
                end else if (r_mode == tcc_pkg::MODE_SET_MIN) begin
                    n_minutes = (r_minutes >= 6'd59) ? 6'd0 : r_minutes + 6'd1;
                end
            end
            tcc_pkg::CMD_DOWN: begin
                if (r_mode == tcc_pkg::MODE_SET_HRS) begin
                    n_hours = (r_hours == 5'd0 || r_hours > 5'd23) ? 5'd23 : r_hours - 5'd1;
                end else if (r_mode == tcc_pkg::MODE_SET_MIN) begin
                    n_minutes = (r_minutes == 6'd0 || r_minutes > 6'd59) ?
                                6'd59 : r_minutes - 6'd1;
                end
            end
            tcc_pkg::CMD_CHIME: begin
                if (r_mode != tcc_pkg::MODE_RUN) begin
                    n_mode = tcc_pkg::MODE_RUN;
                end else if (r_minutes != 6'd0 ||
                             (r_seconds != 6'd0 && r_seconds != 6'd1)) begin
                    n_chime = ~r_chime;
                end
            end
            tcc_pkg::CMD_SERIAL: begin
                n_rvalid = 1'b1;
                case (r_byte)
                    tcc_pkg::RD_HOURS:   n_rbyte = {3'd0, r_hours};
                    tcc_pkg::RD_MINUTES: n_rbyte = {2'd0, r_minutes};
                    tcc_pkg::RD_SECONDS: n_rbyte = {2'd0, r_seconds};
                    tcc_pkg::RD_PHASE:   n_rbyte = {7'd0, r_phase};
                    tcc_pkg::RD_PHASE_B: n_rbyte = {7'd0, r_phase};
                    tcc_pkg::RD_MODE:    n_rbyte = {6'd0, r_mode};
                    tcc_pkg::RD_CHIME:   n_rbyte = {7'd0, r_chime};
                    tcc_pkg::RD_DRIFT:   n_rbyte = w_readout;
                    default: begin
                        if (r_byte < tcc_pkg::SET_END) begin
                            if (r_byte < tcc_pkg::SET_MIN_BASE) begin
                                n_hours = 5'(r_byte - tcc_pkg::SET_HRS_BASE);
                            end else if (r_byte < tcc_pkg::SET_SEC_BASE) begin
                                n_minutes = 6'(r_byte - tcc_pkg::SET_MIN_BASE);
                            end else begin
                                n_seconds = 6'(r_byte - tcc_pkg::SET_SEC_BASE);
                                n_drift   = '0;
                                n_tick    = '0;
                            end
                            n_rbyte = tcc_pkg::REPLY_OK;
                        end else begin
                            n_rbyte = tcc_pkg::REPLY_BAD;
                        end
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd  <= i_command;
            r_byte <= i_serial_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drift_period <= tcc_pkg::RST_DRIFT_PERIOD;
            r_tps          <= tcc_pkg::RST_TICKS_PER_SEC;
            r_report_div   <= tcc_pkg::RST_REPORT_DIV;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tcc_pkg::CFG_DRIFT_PERIOD:  r_drift_period <= i_cfg_data;
                tcc_pkg::CFG_TICKS_PER_SEC: r_tps          <= i_cfg_data[7:0];
                tcc_pkg::CFG_REPORT_DIV:    r_report_div   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick    <= '0;
            r_drift   <= '0;
            r_hours   <= tcc_pkg::RST_HOURS;
            r_minutes <= tcc_pkg::RST_MINUTES;
            r_seconds <= tcc_pkg::RST_SECONDS;
            r_mode    <= tcc_pkg::MODE_RUN;
            r_phase   <= 1'b0;
            r_chime   <= 1'b0;
        end else if (i_ctrl.exec) begin
            r_tick    <= n_tick;
            r_drift   <= n_drift;
            r_hours   <= n_hours;
            r_minutes <= n_minutes;
            r_seconds <= n_seconds;
            r_mode    <= n_mode;
            r_phase   <= n_phase;
            r_chime   <= n_chime;
        end
    end

    // result register, loaded with the new state or the drift readout
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.exec || i_ctrl.load_div) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec || i_ctrl.load_div) begin
            r_reply_valid <= n_rvalid;
            r_reply_byte  <= n_rbyte;
            r_hours_o     <= n_hours;
            r_minutes_o   <= n_minutes;
            r_seconds_o   <= n_seconds;
            r_mode_o      <= n_mode;
            r_phase_o     <= n_phase;
            r_chime_o     <= n_chime;
            r_dpulse_o    <= n_dpulse;
            r_ctoggle_o   <= n_ctoggle;
        end
    end

    assign o_stat.is_read_drift = (r_cmd == tcc_pkg::CMD_SERIAL) &&
                                  (r_byte == tcc_pkg::RD_DRIFT);
    assign o_stat.div_done      = w_div_done;
    assign o_stat.out_free      = !r_out_valid || !i_stall;

    assign o_valid        = r_out_valid;
    assign o_reply_valid  = r_reply_valid;
    assign o_reply_byte   = r_reply_byte;
    assign o_hours_now    = r_hours_o;
    assign o_minutes_now  = r_minutes_o;
    assign o_seconds_now  = r_seconds_o;
    assign o_mode_now     = r_mode_o;
    assign o_phase_now    = r_phase_o;
    assign o_chime_on     = r_chime_o;
    assign o_drift_pulse  = r_dpulse_o;
    assign o_chime_toggle = r_ctoggle_o;

endmodule

FILE: design/tcc_ctrl.sv
// request sequencer: capture, execute, drift readout divide, result load
// depends on tcc_pkg
module tcc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  tcc_pkg::t_ctrl_stat  i_stat,
    output tcc_pkg::t_ctrl_cmd   o_ctrl
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_WRITE = 2'd3;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state          = r_state;
        o_ctrl.capture   = 1'b0;
        o_ctrl.exec      = 1'b0;
        o_ctrl.div_start = 1'b0;
        o_ctrl.load_div  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctrl.capture = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_read_drift) begin
                    o_ctrl.div_start = 1'b1;
                    n_state          = S_DIV;
                end else if (i_stat.out_free) begin
                    o_ctrl.exec = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (i_stat.out_free) begin
                    o_ctrl.load_div = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

FILE: design/trimmed_clock_with_chime_core.sv
// hours:minutes:seconds clock with drift trim, hourly chime and serial access
// top level; depends on tcc_pkg, tcc_ctrl, tcc_datapath, assert_macros.svh
//
// Input channel i_valid/o_stall carries one request: a tick, a key press or a
// serial byte. Output channel o_valid/i_stall returns one result per request:
// the time, mode and flags after the request, plus a reply byte for serial
// requests. Configuration (drift period, ticks per second, report divisor)
// is written through i_cfg_we/i_cfg_index/i_cfg_data; the user is to write
// it only while the block is idle, which the block itself does not enforce.
// A request is captured in S_IDLE and executed in S_EXEC once the result
// register is free, which loads the result; the sequencer then returns to
// S_IDLE for the next request. Serial read of the drift readout runs a
// 16-step bit-serial divider in S_DIV and loads the result from S_WRITE.
// The result register lets the next request be accepted while a result
// waits; a stalled result holds and the next one waits behind it.
// Synchronous active-low reset sets the time to 11:59:57, run mode, chime
// off, and restores the configuration defaults.
`include "assert_macros.svh"
module trimmed_clock_with_chime_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_serial_byte,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_reply_valid,
    output logic [7:0]  o_reply_byte,
    output logic [4:0]  o_hours_now,
    output logic [5:0]  o_minutes_now,
    output logic [5:0]  o_seconds_now,
    output logic [1:0]  o_mode_now,
    output logic        o_phase_now,
    output logic        o_chime_on,
    output logic        o_drift_pulse,
    output logic        o_chime_toggle
);

    tcc_pkg::t_ctrl_cmd  w_ctrl;
    tcc_pkg::t_ctrl_stat w_stat;
    logic                w_load;

    tcc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    tcc_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .o_stat         (w_stat),
        .i_command      (i_command),
        .i_serial_byte  (i_serial_byte),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_reply_valid  (o_reply_valid),
        .o_reply_byte   (o_reply_byte),
        .o_hours_now    (o_hours_now),
        .o_minutes_now  (o_minutes_now),
        .o_seconds_now  (o_seconds_now),
        .o_mode_now     (o_mode_now),
        .o_phase_now    (o_phase_now),
        .o_chime_on     (o_chime_on),
        .o_drift_pulse  (o_drift_pulse),
        .o_chime_toggle (o_chime_toggle)
    );

    assign w_load = w_ctrl.exec || w_ctrl.load_div;

    `TCC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `TCC_ASSERT_SAME(a_load_into_free, i_clk, i_rst_n, w_load, w_stat.out_free)
    `TCC_ASSERT_SAME(a_valid_from_load, i_clk, i_rst_n, $rose(o_valid), $past(w_load))

endmodule
